@@ design/otq_pkg.sv @@
// Shared types and codes for the ordered timer queue.
package otq_pkg;

	localparam logic [1:0] REQ_ADD    = 2'd0;
	localparam logic [1:0] REQ_CANCEL = 2'd1;
	localparam logic [1:0] REQ_TICK   = 2'd2;

	localparam logic [1:0] RES_ADD     = 2'd0;
	localparam logic [1:0] RES_CANCEL  = 2'd1;
	localparam logic [1:0] RES_EXPIRED = 2'd2;
	localparam logic [1:0] RES_NONE    = 2'd3;

	localparam int MAX_OUT = 16;
	localparam logic [62:0] TIME_MAX = {63{1'b1}};

	typedef struct packed {
		logic [1:0]  req_type;
		logic [3:0]  timer_slot;
		logic [31:0] timer_seq;
		logic [62:0] expiry_time;
		logic [47:0] repeat_interval;
		logic [62:0] now_time;
	} otq_req_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [3:0]  handle_slot;
		logic [31:0] handle_seq;
		logic        earliest_changed;
		logic        found;
		logic        table_full;
		logic        next_valid;
		logic [62:0] next_expiry;
		logic        last;
	} otq_res_t;

	// controller -> datapath
	typedef struct packed {
		logic load;       // capture request
		logic scan_clr;   // start a scan pass
		logic scan_step;  // examine one slot
		logic do_add;
		logic do_cancel;
		logic emit_pick;  // take picked timer, emit word
		logic emit_plain; // emit add/cancel/none word
		logic emit_last;  // last flag of emitted word
	} otq_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic scan_done;
		logic pick_ok;
		logic [1:0] req_type;
		logic any_v;        // an armed timer was seen in the last pass
		logic [62:0] any_e; // earliest expiry seen in the last pass
	} otq_sts_t;

endpackage

@@ design/otq_datapath.sv @@
// Timer store, slot scanner and result register.
module otq_datapath #(
	parameter int NUM_TIMERS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  otq_pkg::otq_req_t req,
	input  otq_pkg::otq_cmd_t cmd,
	output otq_pkg::otq_sts_t sts,
	output logic              res_strobe,
	output otq_pkg::otq_res_t res
);
	import otq_pkg::*;

	localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int CW = $clog2(NUM_TIMERS + 1);

	logic [NUM_TIMERS-1:0] valid_q, taken_q;
	logic [62:0] exp_q [NUM_TIMERS];
	logic [47:0] ivl_q [NUM_TIMERS];
	logic [31:0] seq_q [NUM_TIMERS];
	logic [31:0] next_seq_q;
	otq_req_t    r_q;
	logic [CW-1:0] idx_q;
	logic [IW-1:0] idx;
	// scan results
	logic          pick_v_q, any_v_q, free_v_q;
	logic [IW-1:0] pick_q, free_q;
	logic [62:0]   pick_e_q, any_e_q;
	logic [4:0]    n_out_q;

	logic [62:0] e_i;
	logic        v_i;
	logic        cand;
	logic        slot_hit;
	logic [IW-1:0] cslot;
	logic        cancel_hit;
	logic [63:0] rearm;
	logic [62:0] rearm_sat;
	otq_res_t    word_d;

	assign idx  = idx_q[IW-1:0];
	assign e_i  = exp_q[idx];
	assign v_i  = valid_q[idx];
	assign cand = v_i && !taken_q[idx] && (e_i <= r_q.now_time)
		&& (n_out_q < 5'(MAX_OUT));
	assign slot_hit = (NUM_TIMERS >= 16) || (32'(r_q.timer_slot) < 32'(NUM_TIMERS));
	assign cslot = IW'(r_q.timer_slot);
	assign cancel_hit = slot_hit && valid_q[cslot] && (seq_q[cslot] == r_q.timer_seq);
	assign rearm = {1'b0, r_q.now_time} + {16'd0, ivl_q[pick_q]};
	assign rearm_sat = rearm[63] ? TIME_MAX : rearm[62:0];

	assign sts.scan_done = (idx_q == CW'(NUM_TIMERS));
	assign sts.pick_ok   = pick_v_q;
	assign sts.req_type  = r_q.req_type;
	assign sts.any_v     = any_v_q;
	assign sts.any_e     = any_e_q;

	// result word for the current emit command
	always_comb begin
		word_d = '0;
		word_d.last = cmd.emit_last;
		if (cmd.emit_pick) begin
			word_d.result_kind = RES_EXPIRED;
			word_d.handle_slot = 4'(pick_q);
			word_d.handle_seq  = seq_q[pick_q];
		end else if (r_q.req_type == REQ_ADD) begin
			word_d.result_kind = RES_ADD;
			word_d.table_full  = !free_v_q;
			if (free_v_q) begin
				word_d.handle_slot      = 4'(free_q);
				word_d.handle_seq       = next_seq_q;
				word_d.earliest_changed = !any_v_q || r_q.expiry_time < any_e_q;
			end
		end else if (r_q.req_type == REQ_CANCEL) begin
			word_d.result_kind = RES_CANCEL;
			word_d.found       = cancel_hit;
		end else begin
			word_d.result_kind = RES_NONE;
		end
		if (cmd.emit_last && r_q.req_type == REQ_TICK) begin
			word_d.next_valid  = any_v_q;
			word_d.next_expiry = any_v_q ? any_e_q : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			next_seq_q <= '0;
			res_strobe <= 1'b0;
			taken_q    <= '0;
			n_out_q    <= '0;
		end else begin
			res_strobe <= cmd.emit_pick || cmd.emit_plain;
			if (cmd.load) begin
				taken_q <= '0;
				n_out_q <= '0;
			end
			if (cmd.do_add && free_v_q) begin
				valid_q[free_q] <= 1'b1;
				next_seq_q      <= next_seq_q + 32'd1;
			end
			if (cmd.do_cancel && cancel_hit)
				valid_q[cslot] <= 1'b0;
			if (cmd.emit_pick) begin
				taken_q[pick_q] <= 1'b1;
				n_out_q <= n_out_q + 5'd1;
				if (ivl_q[pick_q] == '0) valid_q[pick_q] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) r_q <= req;
		if (cmd.do_add && free_v_q) begin
			exp_q[free_q] <= r_q.expiry_time;
			ivl_q[free_q] <= r_q.repeat_interval;
			seq_q[free_q] <= next_seq_q;
		end
		if (cmd.emit_pick && ivl_q[pick_q] != '0) exp_q[pick_q] <= rearm_sat;
		if (cmd.scan_clr) begin
			idx_q    <= '0;
			pick_v_q <= 1'b0;
			any_v_q  <= 1'b0;
			free_v_q <= 1'b0;
		end else if (cmd.scan_step) begin
			idx_q <= idx_q + CW'(1);
			if (cand && (!pick_v_q || e_i < pick_e_q)) begin
				pick_v_q <= 1'b1;
				pick_q   <= idx;
				pick_e_q <= e_i;
			end
			if (v_i && (!any_v_q || e_i < any_e_q)) begin
				any_v_q <= 1'b1;
				any_e_q <= e_i;
			end
			if (!v_i && !free_v_q) begin
				free_v_q <= 1'b1;
				free_q   <= idx;
			end
		end
		if (cmd.emit_pick || cmd.emit_plain)
			res <= word_d;
	end
endmodule

@@ design/otq_ctrl.sv @@
// Sequencer for add, cancel and tick requests.
module otq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [1:0]        req_type,
	input  otq_pkg::otq_sts_t sts,
	output logic              busy,
	output otq_pkg::otq_cmd_t cmd
);
	import otq_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCAN = 3'd1; // find pick/free/earliest
	localparam logic [2:0] ST_DEC  = 3'd2; // act on scan
	localparam logic [2:0] ST_FIN  = 3'd3; // unused; the final earliest scan for tick runs in ST_SCAN
	localparam logic [2:0] ST_SEND = 3'd4; // unused; the top level emits the held pick as last word

	logic [2:0] st_q, st_d;
	logic       held_q, held_d; // a picked timer waits to be emitted

	assign busy = (st_q != ST_IDLE);

	always_comb begin
		cmd    = '0;
		st_d   = st_q;
		held_d = held_q;
		case (st_q)
			ST_IDLE: begin
				if (start && req_type inside {REQ_ADD, REQ_CANCEL, REQ_TICK}) begin
					cmd.load     = 1'b1;
					cmd.scan_clr = 1'b1;
					held_d = 1'b0;
					st_d   = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (sts.scan_done) st_d = ST_DEC;
				else cmd.scan_step = 1'b1;
			end
			ST_DEC: begin
				if (sts.req_type == REQ_ADD) begin
					cmd.emit_plain = 1'b1;
					cmd.emit_last  = 1'b1;
					cmd.do_add     = 1'b1;
					st_d = ST_IDLE;
				end else if (sts.req_type == REQ_CANCEL) begin
					cmd.emit_plain = 1'b1;
					cmd.emit_last  = 1'b1;
					cmd.do_cancel  = 1'b1;
					st_d = ST_IDLE;
				end else if (sts.pick_ok) begin
					// take pick and look for the next; state is updated now
					cmd.emit_pick = 1'b1;
					cmd.scan_clr  = 1'b1;
					held_d = 1'b1;
					st_d   = ST_SCAN;
				end else if (held_q) begin
					st_d = ST_IDLE;
				end else begin
					cmd.emit_plain = 1'b1;
					cmd.emit_last  = 1'b1;
					st_d = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			held_q <= 1'b0;
		end else begin
			st_q   <= st_d;
			held_q <= held_d;
		end
	end
endmodule

@@ design/ordered_timer_queue.sv @@
// Top level of the ordered timer queue.
//
// Channel  Dir  Handshake            Word
// request  in   start & !busy        otq_req_t
// result   out  strobe, one cycle    otq_res_t
//
// Add and cancel run a single slot scan pass; one slot is examined per cycle.
// A tick runs one scan pass per expired timer and then a final pass; each pass
// of the slot scan finds the next timer in expiry order and the final pass
// gives the earliest remaining expiry.
// Reset clears all valid marks and the sequence counter at once.
// The receiver cannot stall; each word is shown for one cycle only.
// Expired words leave one scan pass apart; the last one carries the next expiry.
module ordered_timer_queue #(
	parameter int NUM_TIMERS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  otq_pkg::otq_req_t req,
	output logic              strobe,
	output otq_pkg::otq_res_t res
);
	import otq_pkg::*;

	otq_cmd_t cmd;
	otq_sts_t sts;
	otq_res_t dp_res;
	logic     dp_strobe;
	logic     hold_v_q;   // previous expired word waiting for its successor
	otq_res_t hold_q;
	otq_res_t fin_w;      // held word closed out as the last of the tick
	logic     tick_done;

	otq_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .req_type(req.req_type),
		.sts(sts), .busy(busy), .cmd(cmd)
	);

	otq_datapath #(.NUM_TIMERS(NUM_TIMERS)) u_dp (
		.clk(clk), .arst_n(arst_n), .req(req), .cmd(cmd), .sts(sts),
		.res_strobe(dp_strobe), .res(dp_res)
	);

	// Expired words are held one pass so the last can carry the next expiry,
	// known only after the final scan.
	assign tick_done = (sts.req_type == REQ_TICK) && sts.scan_done && !sts.pick_ok
		&& !cmd.scan_step && busy && !cmd.load && hold_v_q && !dp_strobe;

	always_comb begin
		fin_w             = hold_q;
		fin_w.last        = 1'b1;
		fin_w.next_valid  = sts.any_v;
		fin_w.next_expiry = sts.any_v ? sts.any_e : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
			strobe   <= 1'b0;
		end else begin
			strobe <= 1'b0;
			if (dp_strobe && dp_res.result_kind == RES_EXPIRED) begin
				if (hold_v_q) strobe <= 1'b1;
				hold_v_q <= 1'b1;
			end else if (dp_strobe) begin
				strobe <= 1'b1;
			end else if (tick_done) begin
				strobe   <= 1'b1;
				hold_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dp_strobe && dp_res.result_kind == RES_EXPIRED) begin
			hold_q <= dp_res;
			res    <= hold_q;
		end else if (dp_strobe) begin
			res <= dp_res;
		end else if (tick_done) begin
			res <= fin_w;
		end
	end
endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for the ordered timer queue: directed table, then random traffic.
module tb_top;
	import otq_pkg::*;

	localparam int NT = 16;
	localparam int WATCHDOG = 20000;
	localparam logic [1:0] REQ_RSVD = 2'd3; // unused request code

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     start = 1'b0;
	logic     busy;
	otq_req_t req = '0;
	logic     strobe;
	otq_res_t res;

	ordered_timer_queue #(.NUM_TIMERS(NT)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req(req), .strobe(strobe), .res(res)
	);

	always #5 clk = ~clk;

	// shadow copy of the timer table
	logic        tq_valid [NT];
	logic [62:0] tq_expiry [NT];
	logic [47:0] tq_ivl [NT];
	logic [31:0] tq_seq [NT];
	logic [31:0] seq_ctr;

	otq_res_t pending_words[$];
	int errors = 0;
	int n_words = 0;
	int n_expired = 0;
	int n_full = 0;
	int n_found = 0;
	int idle_cycles = 0;
	int send_idle_pct = 36;

	// earliest expiry among armed timers
	function automatic logic earliest(output logic [62:0] when);
		logic any;
		any = 1'b0;
		when = '0;
		for (int i = 0; i < NT; i++)
			if (tq_valid[i] && (!any || tq_expiry[i] < when)) begin
				when = tq_expiry[i];
				any = 1'b1;
			end
		return any;
	endfunction

	function automatic otq_res_t blank_word(logic [1:0] kind);
		otq_res_t w;
		w = '0;
		w.result_kind = kind;
		w.last = 1'b1;
		return w;
	endfunction

	// apply one request to the shadow table and queue the words it yields
	task automatic predict_request(input otq_req_t r);
		otq_res_t w;
		int free_slot, n, pick;
		int order[MAX_OUT];
		logic taken[NT];
		logic any;
		logic [62:0] best;
		logic [63:0] sum;
		free_slot = -1;
		n = 0;
		case (r.req_type)
		REQ_ADD: begin
			w = blank_word(RES_ADD);
			for (int i = NT - 1; i >= 0; i--)
				if (!tq_valid[i])
					free_slot = i;
			if (free_slot < 0) begin
				w.table_full = 1'b1;
			end else begin
				any = earliest(best);
				w.earliest_changed = !any || r.expiry_time < best;
				w.handle_slot = free_slot[3:0];
				w.handle_seq = seq_ctr;
				tq_valid[free_slot] = 1'b1;
				tq_expiry[free_slot] = r.expiry_time;
				tq_ivl[free_slot] = r.repeat_interval;
				tq_seq[free_slot] = seq_ctr;
				seq_ctr = seq_ctr + 32'd1;
			end
			pending_words.push_back(w);
		end
		REQ_CANCEL: begin
			w = blank_word(RES_CANCEL);
			if (tq_valid[r.timer_slot] && tq_seq[r.timer_slot] == r.timer_seq) begin
				tq_valid[r.timer_slot] = 1'b0;
				w.found = 1'b1;
			end
			pending_words.push_back(w);
		end
		REQ_TICK: begin
			for (int i = 0; i < NT; i++)
				taken[i] = 1'b0;
			// repeated min search: expiry order, lower slot wins ties
			while (n < MAX_OUT) begin
				pick = -1;
				for (int i = 0; i < NT; i++)
					if (tq_valid[i] && !taken[i] && tq_expiry[i] <= r.now_time &&
					    (pick < 0 || tq_expiry[i] < tq_expiry[pick]))
						pick = i;
				if (pick < 0)
					break;
				taken[pick] = 1'b1;
				order[n] = pick;
				n++;
			end
			for (int k = 0; k < n; k++)
				if (tq_ivl[order[k]] != 0) begin
					sum = {1'b0, r.now_time} + {16'd0, tq_ivl[order[k]]};
					tq_expiry[order[k]] = sum[63] ? TIME_MAX : sum[62:0];
				end else begin
					tq_valid[order[k]] = 1'b0;
				end
			any = earliest(best);
			if (n == 0) begin
				w = blank_word(RES_NONE);
				w.next_valid = any;
				w.next_expiry = best;
				pending_words.push_back(w);
			end
			for (int k = 0; k < n; k++) begin
				w = blank_word(RES_EXPIRED);
				w.handle_slot = order[k][3:0];
				w.handle_seq = tq_seq[order[k]];
				w.last = (k == n - 1);
				w.next_valid = w.last && any;
				w.next_expiry = w.last ? best : '0;
				pending_words.push_back(w);
			end
		end
		default: ;
		endcase
	endtask

	// result checker and watchdog
	always @(posedge clk) begin
		otq_res_t e;
		if (strobe || (start && !busy))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("Simulation FAILED");
			$finish;
		end
		if (arst_n && strobe) begin
			n_words++;
			if (pending_words.size() == 0) begin
				$error("unexpected result word kind=%0d", res.result_kind);
				errors++;
			end else begin
				e = pending_words.pop_front();
				if (res.result_kind == RES_EXPIRED) n_expired++;
				if (res.table_full) n_full++;
				if (res.found) n_found++;
				if (res.result_kind !== e.result_kind) begin
					$error("result_kind exp %0d got %0d", e.result_kind, res.result_kind); errors++; end
				if (res.handle_slot !== e.handle_slot) begin
					$error("handle_slot exp %0d got %0d", e.handle_slot, res.handle_slot); errors++; end
				if (res.handle_seq !== e.handle_seq) begin
					$error("handle_seq exp %0h got %0h", e.handle_seq, res.handle_seq); errors++; end
				if (res.earliest_changed !== e.earliest_changed) begin
					$error("earliest_changed exp %0b got %0b", e.earliest_changed,
						res.earliest_changed); errors++; end
				if (res.found !== e.found) begin
					$error("found exp %0b got %0b", e.found, res.found); errors++; end
				if (res.table_full !== e.table_full) begin
					$error("table_full exp %0b got %0b", e.table_full, res.table_full); errors++; end
				if (res.next_valid !== e.next_valid) begin
					$error("next_valid exp %0b got %0b", e.next_valid, res.next_valid); errors++; end
				if (res.next_expiry !== e.next_expiry) begin
					$error("next_expiry exp %0h got %0h", e.next_expiry, res.next_expiry); errors++; end
				if (res.last !== e.last) begin
					$error("last exp %0b got %0b", e.last, res.last); errors++; end
			end
		end
	end

	// hand one word to the block; random gaps before it, held until taken
	task automatic issue(input otq_req_t r);
		if ($urandom_range(99) < send_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predict_request(r);
	endtask

	function automatic otq_req_t mk(logic [1:0] kind, logic [3:0] slot, logic [31:0] sq,
		logic [62:0] expv, logic [47:0] ivl, logic [62:0] now);
		otq_req_t r;
		r.req_type = kind;
		r.timer_slot = slot;
		r.timer_seq = sq;
		r.expiry_time = expv;
		r.repeat_interval = ivl;
		r.now_time = now;
		return r;
	endfunction

	function automatic logic [62:0] rnd63();
		return 63'({$urandom(), $urandom()});
	endfunction

	// random traffic: adds near a running clock, cancels of live and stale handles, ticks, reserved codes
	task automatic random_phase(input int count);
		logic [62:0] now_t;
		logic [47:0] ivl;
		int s, sel;
		now_t = 63'd1000;
		for (int i = 0; i < count; i++) begin
			sel = $urandom_range(99);
			if (sel < 45) begin
				ivl = ($urandom_range(2) == 0) ? 48'd0 :
					($urandom_range(9) == 0) ? 48'({$urandom(), $urandom()}) :
					48'($urandom_range(300));
				issue(mk(REQ_ADD, 4'($urandom()), $urandom(),
					($urandom_range(19) == 0) ? rnd63() : now_t + 63'($urandom_range(500)),
					ivl, rnd63()));
			end else if (sel < 65) begin
				s = $urandom_range(NT - 1);
				issue(mk(REQ_CANCEL, 4'(s),
					($urandom_range(3) == 0) ? $urandom() : (tq_valid[s] ? tq_seq[s] : seq_ctr),
					rnd63(), 48'($urandom()), rnd63()));
			end else if (sel < 97) begin
				now_t = now_t + 63'($urandom_range(400));
				issue(mk(REQ_TICK, 4'($urandom()), $urandom(), rnd63(), 48'($urandom()),
					($urandom_range(29) == 0) ? TIME_MAX : now_t));
			end else begin
				issue(mk(REQ_RSVD, 4'($urandom()), $urandom(), rnd63(), 48'($urandom()),
					rnd63()));
			end
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
	endtask

	// directed table; rows with typed clear are checked by the predictor only
	typedef struct {
		otq_req_t  r;
		logic      typed;
		otq_res_t  want;
	} stim_row_t;

	stim_row_t rows[$];
	otq_res_t  w;

	initial begin
		for (int i = 0; i < NT; i++) begin
			tq_valid[i] = 1'b0;
			tq_expiry[i] = '0;
			tq_ivl[i] = '0;
			tq_seq[i] = '0;
		end
		seq_ctr = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// tick on empty table right after reset
		w = blank_word(RES_NONE);
		rows.push_back('{mk(REQ_TICK, '0, '0, '0, '0, TIME_MAX), 1'b1, w});
		// cancel on empty table
		w = blank_word(RES_CANCEL);
		rows.push_back('{mk(REQ_CANCEL, 4'hF, '1, '1, '1, '1), 1'b1, w});
		// first add: slot 0, seq 0, earliest
		w = blank_word(RES_ADD);
		w.earliest_changed = 1'b1;
		rows.push_back('{mk(REQ_ADD, 4'hF, '1, TIME_MAX, '1, '0), 1'b1, w});
		// fill the rest, including a zero expiry and ties
		for (int i = 1; i < NT; i++)
			rows.push_back('{mk(REQ_ADD, '0, '0, (i == 1) ? 63'd0 : 63'd50,
				(i % 3 == 0) ? 48'd10 : 48'd0, '0), 1'b0, w});
		// table full
		w = blank_word(RES_ADD);
		w.table_full = 1'b1;
		rows.push_back('{mk(REQ_ADD, '0, '0, 63'd5, 48'd5, '0), 1'b1, w});
		// cancel with wrong sequence, then a good one
		w = blank_word(RES_CANCEL);
		rows.push_back('{mk(REQ_CANCEL, 4'd2, 32'd99, '0, '0, '0), 1'b1, w});
		w.found = 1'b1;
		rows.push_back('{mk(REQ_CANCEL, 4'd2, 32'd2, '0, '0, '0), 1'b1, w});
		// tick with fourteen due, ties by slot
		rows.push_back('{mk(REQ_TICK, '0, '0, '0, '0, 63'd60), 1'b0, w});
		// max time tick: saturating re-arm of the maximal interval timer
		rows.push_back('{mk(REQ_TICK, '0, '0, '0, '0, TIME_MAX), 1'b0, w});
		// unknown request yields nothing
		rows.push_back('{mk(REQ_RSVD, '1, '1, '1, '1, '1), 1'b0, w});
		rows.push_back('{mk(REQ_TICK, '0, '0, '0, '0, TIME_MAX), 1'b0, w});

		foreach (rows[i]) begin
			issue(rows[i].r);
			// typed rows must agree with the predictor before it is trusted
			if (rows[i].typed && pending_words[pending_words.size() - 1] !== rows[i].want) begin
				$error("table row %0d: predictor disagrees with typed result", i);
				errors++;
			end
		end
		drain();

		random_phase(130);
		// hold off until the block has emptied its output
		drain();
		send_idle_pct = 51;
		random_phase(130);
		send_idle_pct = 0;
		random_phase(110);

		drain();
		repeat (20 * (NT + 2) * 2) @(posedge clk);
		$display("Covered %0d result words: %0d expirations, %0d table-full, %0d cancels hit.",
			n_words, n_expired, n_full, n_found);
		if (errors == 0 && pending_words.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

@@ filelist.f @@
design/otq_pkg.sv
design/otq_datapath.sv
design/otq_ctrl.sv
design/ordered_timer_queue.sv
verif/tb_top.sv
